@@ rtl/pptr_pkg.sv @@
// Shared types and constants for the private reverse-pointer query filter.
// Depends on nothing; imported by private_ptr_query_filter.
package pptr_pkg;

  // Name bytes that count toward one query name
  localparam int NAME_LIMIT = 127;
  localparam int TAKEN_W    = $clog2(NAME_LIMIT + 1);

  // Length of the reverse-zone suffix and of the delay line that holds it back
  localparam int WIN_LEN = 13;

  // Configuration port layout
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int TYPE_W  = 16;

  // Register indexes (paddr word address)
  localparam logic REG_PTR_TYPE = 1'b0;

  localparam logic [TYPE_W-1:0] PTR_TYPE_RESET = 16'd12;

  typedef logic [7:0] byte_t;
  typedef byte_t      window_t [WIN_LEN];

  // ".in-addr.arpa", oldest byte first
  localparam byte_t SUFFIX_PAT [WIN_LEN] = '{
    8'h2e, 8'h69, 8'h6e, 8'h2d, 8'h61, 8'h64, 8'h64,
    8'h72, 8'h2e, 8'h61, 8'h72, 8'h70, 8'h61
  };

  // Label reader phases
  typedef enum logic [1:0] {
    TOK_NONE   = 2'd0,
    TOK_BLANK  = 2'd1,
    TOK_DIGIT  = 2'd2,
    TOK_FROZEN = 2'd3
  } tok_phase_t;

  // Private address prefixes as seen in the two top labels
  localparam byte_t OCT_TEN     = 8'd10;
  localparam byte_t OCT_172     = 8'd172;
  localparam byte_t OCT_192     = 8'd192;
  localparam byte_t OCT_168     = 8'd168;
  localparam byte_t MASK_172_LO = 8'hf0;
  localparam byte_t PREF_172_LO = 8'h10;

endpackage

@@ rtl/private_ptr_query_filter.sv @@
// Top level of the private reverse-pointer query filter: window match,
// label reader, judgment and result register. Depends on pptr_pkg.
//
//  channel  | dir | handshake               | contents
//  ---------+-----+-------------------------+------------------------------------
//  s_*      | in  | s_tvalid / s_tready     | one name byte per request, query type
//  m_*      | out | m_tvalid / m_tready     | one is_private flag per finished name
//  apb      | in  | psel, penable, pready=1 | ptr_type_code at byte address 0
//
// One request per cycle while s_tready is high: each byte is matched, tokenized and judged in the
// cycle it is accepted, and a result lands in the output register at that edge.
// s_tready drops only while a result waits in the output register and is not
// being taken in the same cycle. Reset (rst, synchronous) clears the parse
// state and restores ptr_type_code to 12; no clearing pass is needed.
module private_ptr_query_filter (
  input  logic                         clk,
  input  logic                         rst,
  // Request stream
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [23:0]                  s_tdata,  // [7:0] name_byte, [23:8] query_type
  input  logic [1:0]                   s_tuser,  // [0] byte_present, [1] first_of_name
  input  logic                         s_tlast,  // last_of_name
  // Result stream
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [7:0]                   m_tdata,  // [0] is_private, [7:1] zero
  // Configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pptr_pkg::PADDR_W-1:0] paddr,
  input  logic [pptr_pkg::PDATA_W-1:0] pwdata,
  output logic [pptr_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import pptr_pkg::*;

  // Registers
  logic [TYPE_W-1:0]  ptr_type_code;
  window_t            match_window;
  logic [TAKEN_W-1:0] bytes_taken;
  logic               suffix_found;
  logic               name_ended;
  logic [TYPE_W-1:0]  latched_type;
  tok_phase_t         token_phase;
  logic               token_negative;
  byte_t              token_value;
  byte_t              last_token;
  byte_t              prior_token;
  logic               is_private;

  // Next values
  window_t            match_window_next;
  logic [TAKEN_W-1:0] bytes_taken_next;
  logic               suffix_found_next;
  logic               name_ended_next;
  logic [TYPE_W-1:0]  latched_type_next;
  tok_phase_t         token_phase_next;
  logic               token_negative_next;
  byte_t              token_value_next;
  byte_t              last_token_next;
  byte_t              prior_token_next;
  logic               is_private_next;

  // Request fields
  byte_t             name_byte;
  logic [TYPE_W-1:0] query_type;
  logic              byte_present;
  logic              first_of_name;
  logic              last_of_name;
  logic              s_accept;

  // Working signals
  logic  take_byte;
  logic  win_match;
  byte_t tok_byte;
  logic  tok_digit;
  byte_t digit_val;
  byte_t open_value;
  byte_t judge_hi;
  byte_t judge_lo;

  assign name_byte     = s_tdata[7:0];
  assign query_type    = s_tdata[23:8];
  assign byte_present  = s_tuser[0];
  assign first_of_name = s_tuser[1];
  assign last_of_name  = s_tlast;

  assign s_tready = !m_tvalid || m_tready;
  assign s_accept = s_tvalid && s_tready;
  assign m_tdata  = {7'd0, is_private};

  // Configuration access
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1] == REG_PTR_TYPE) ?
                  {{(PDATA_W-TYPE_W){1'b0}}, ptr_type_code} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr_type_code <= PTR_TYPE_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[PADDR_W-1] == REG_PTR_TYPE) begin
      ptr_type_code <= pwdata[TYPE_W-1:0];
    end
  end

  // Parse update for one request, then judgment on the updated state
  always_comb begin
    // start from a cleared parse on the first byte of a name
    if (first_of_name) begin
      for (int i = 0; i < WIN_LEN; i++) match_window_next[i] = '0;
      bytes_taken_next    = '0;
      suffix_found_next   = 1'b0;
      name_ended_next     = 1'b0;
      latched_type_next   = query_type;
      token_phase_next    = TOK_NONE;
      token_negative_next = 1'b0;
      token_value_next    = '0;
      last_token_next     = '0;
      prior_token_next    = '0;
    end else begin
      match_window_next   = match_window;
      bytes_taken_next    = bytes_taken;
      suffix_found_next   = suffix_found;
      name_ended_next     = name_ended;
      latched_type_next   = latched_type;
      token_phase_next    = token_phase;
      token_negative_next = token_negative;
      token_value_next    = token_value;
      last_token_next     = last_token;
      prior_token_next    = prior_token;
    end

    take_byte = byte_present && !name_ended_next && !suffix_found_next &&
                (bytes_taken_next < TAKEN_W'(NAME_LIMIT));
    tok_byte  = match_window_next[0];
    tok_digit = (tok_byte >= 8'h30) && (tok_byte <= 8'h39);
    digit_val = tok_byte - 8'h30;
    win_match = 1'b0;

    if (take_byte && name_byte == 8'h00) begin
      name_ended_next = 1'b1;
    end else if (take_byte) begin
      // feed the byte leaving the delay line to the label reader
      if (bytes_taken_next >= TAKEN_W'(WIN_LEN)) begin
        if (tok_byte == 8'h2e) begin
          if (token_phase_next != TOK_NONE) begin
            prior_token_next = last_token_next;
            last_token_next  = token_negative_next ? 8'd0 - token_value_next
                                                   : token_value_next;
            token_phase_next = TOK_NONE;
          end
        end else begin
          if (token_phase_next == TOK_NONE) begin
            token_phase_next    = TOK_BLANK;
            token_negative_next = 1'b0;
            token_value_next    = '0;
          end
          case (token_phase_next)
            TOK_BLANK: begin
              if (tok_byte inside {8'h20, [8'h09:8'h0d]}) begin
                token_phase_next = TOK_BLANK;
              end else if (tok_byte == 8'h2b || tok_byte == 8'h2d) begin
                token_negative_next = (tok_byte == 8'h2d);
                token_phase_next    = TOK_DIGIT;
              end else if (tok_digit) begin
                token_value_next = digit_val;
                token_phase_next = TOK_DIGIT;
              end else begin
                token_phase_next = TOK_FROZEN;
              end
            end
            TOK_DIGIT: begin
              if (tok_digit) begin
                token_value_next = (token_value_next << 3) + (token_value_next << 1)
                                   + digit_val;
              end else begin
                token_phase_next = TOK_FROZEN;
              end
            end
            default: begin
              token_phase_next = token_phase_next;
            end
          endcase
        end
      end

      // advance the delay line and look for the suffix
      for (int i = 0; i < WIN_LEN - 1; i++) match_window_next[i] = match_window_next[i+1];
      match_window_next[WIN_LEN-1] = name_byte;
      win_match = 1'b1;
      for (int i = 0; i < WIN_LEN; i++) begin
        if (match_window_next[i] != SUFFIX_PAT[i]) win_match = 1'b0;
      end
      if (bytes_taken_next >= TAKEN_W'(WIN_LEN - 1) && win_match) suffix_found_next = 1'b1;
      bytes_taken_next = bytes_taken_next + TAKEN_W'(1);
    end

    // pick the two top labels, an open label counting as the last one
    open_value = token_negative_next ? 8'd0 - token_value_next : token_value_next;
    if (token_phase_next != TOK_NONE) begin
      judge_hi = open_value;
      judge_lo = last_token_next;
    end else begin
      judge_hi = last_token_next;
      judge_lo = prior_token_next;
    end

    is_private_next = (latched_type_next == ptr_type_code) && suffix_found_next &&
                      ((judge_hi == OCT_TEN) ||
                       (judge_hi == OCT_172 && (judge_lo & MASK_172_LO) == PREF_172_LO) ||
                       (judge_hi == OCT_192 && judge_lo == OCT_168));
  end

  // Parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WIN_LEN; i++) match_window[i] <= '0;
      bytes_taken    <= '0;
      suffix_found   <= 1'b0;
      name_ended     <= 1'b0;
      latched_type   <= '0;
      token_phase    <= TOK_NONE;
      token_negative <= 1'b0;
      token_value    <= '0;
      last_token     <= '0;
      prior_token    <= '0;
    end else if (s_accept) begin
      match_window   <= match_window_next;
      bytes_taken    <= bytes_taken_next;
      suffix_found   <= suffix_found_next;
      name_ended     <= name_ended_next;
      latched_type   <= latched_type_next;
      token_phase    <= token_phase_next;
      token_negative <= token_negative_next;
      token_value    <= token_value_next;
      last_token     <= last_token_next;
      prior_token    <= prior_token_next;
    end
  end

  // Result register: load on the last byte of a name, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_accept && last_of_name) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept && last_of_name) begin
      is_private <= is_private_next;
    end
  end

endmodule

@@ sim/tb_private_ptr_query_filter.sv @@
// Self-checking bench for private_ptr_query_filter: streams reverse-zone names
// byte by byte, predicts each is_private flag, and checks the result stream.
// Depends on pptr_pkg and private_ptr_query_filter.
`timescale 1ns / 100ps

module tb_private_ptr_query_filter;
  import pptr_pkg::*;

  // Character codes seen by the label reader
  localparam byte_t CH_DOT   = 8'h2e;
  localparam byte_t CH_ZERO  = 8'h30;
  localparam byte_t CH_NINE  = 8'h39;
  localparam byte_t CH_SPACE = 8'h20;
  localparam byte_t CH_PLUS  = 8'h2b;
  localparam byte_t CH_MINUS = 8'h2d;
  localparam byte_t CH_TAB   = 8'h09;
  localparam byte_t CH_CR    = 8'h0d;
  localparam byte_t CH_NUL   = 8'h00;

  localparam logic [PADDR_W-1:0] PTR_TYPE_ADDR = PADDR_W'(4 * REG_PTR_TYPE);

  typedef struct packed {
    byte_t       name_byte;
    logic        present;
    logic [15:0] qtype;
    logic        first;
    logic        last;
  } name_req_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid;
  logic                s_tready;
  logic [23:0]         s_tdata;  // [7:0] name_byte, [23:8] query_type
  logic [1:0]          s_tuser;  // [0] byte_present, [1] first_of_name
  logic                s_tlast;  // last_of_name
  logic                m_tvalid;
  logic                m_tready;
  logic [7:0]          m_tdata;  // [0] is_private, [7:1] zero
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  private_ptr_query_filter i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Stimulus and scoreboard storage
  name_req_t   req_q [$];
  byte_t       name_buf [$];
  bit          verdict_q [$];
  int unsigned pushed_cnt = 0;
  int unsigned fail_cnt   = 0;
  bit          req_on_bus = 1'b0;
  bit          steady     = 1'b0;
  int unsigned send_gap   = 0;
  int unsigned take_stall = 0;

  // Filter state mirrored by the predictor
  byte_t       win_q [WIN_LEN];
  int unsigned taken_cnt;
  bit          suffix_hit;
  bit          name_done;
  logic [15:0] held_type;
  logic [15:0] ptr_type_now;
  tok_phase_t  lab_phase;
  bit          lab_neg;
  byte_t       lab_val;
  byte_t       top_label;
  byte_t       next_label;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function void restart_name();
    foreach (win_q[i]) win_q[i] = CH_NUL;
    taken_cnt  = 0;
    suffix_hit = 1'b0;
    name_done  = 1'b0;
    lab_phase  = TOK_NONE;
    lab_neg    = 1'b0;
    lab_val    = 8'h00;
    top_label  = 8'h00;
    next_label = 8'h00;
  endfunction

  function byte_t open_label();
    return lab_neg ? byte_t'(8'h00 - lab_val) : lab_val;
  endfunction

  function void read_label_char(byte_t c);
    bit is_digit;
    bit is_blank;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    is_blank = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    // a dot closes the open label and shifts the last two
    if (c == CH_DOT) begin
      if (lab_phase != TOK_NONE) begin
        next_label = top_label;
        top_label  = open_label();
        lab_phase  = TOK_NONE;
      end
      return;
    end
    if (lab_phase == TOK_NONE) begin
      lab_phase = TOK_BLANK;
      lab_neg   = 1'b0;
      lab_val   = 8'h00;
    end
    case (lab_phase)
      TOK_BLANK: begin
        if (is_blank) begin
          lab_phase = TOK_BLANK;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          lab_neg   = (c == CH_MINUS);
          lab_phase = TOK_DIGIT;
        end else if (is_digit) begin
          lab_val   = c - CH_ZERO;
          lab_phase = TOK_DIGIT;
        end else begin
          lab_phase = TOK_FROZEN;
        end
      end
      TOK_DIGIT: begin
        if (is_digit) lab_val = byte_t'(lab_val * 10 + (c - CH_ZERO));
        else lab_phase = TOK_FROZEN;
      end
      default: ;
    endcase
  endfunction

  function void shift_in_byte(byte_t c);
    bit same;
    if (name_done || suffix_hit || taken_cnt >= NAME_LIMIT) return;
    if (c == CH_NUL) begin
      name_done = 1'b1;
      return;
    end
    // the oldest window byte reaches the label reader once the window is full
    if (taken_cnt >= WIN_LEN) read_label_char(win_q[0]);
    for (int i = 0; i < WIN_LEN - 1; i++) win_q[i] = win_q[i+1];
    win_q[WIN_LEN-1] = c;
    taken_cnt++;
    same = 1'b1;
    foreach (win_q[i]) if (win_q[i] != SUFFIX_PAT[i]) same = 1'b0;
    if (taken_cnt >= WIN_LEN && same) suffix_hit = 1'b1;
  endfunction

  function bit private_verdict();
    byte_t hi;
    byte_t lo;
    hi = top_label;
    lo = next_label;
    if (held_type != ptr_type_now || !suffix_hit) return 1'b0;
    if (lab_phase != TOK_NONE) begin
      lo = top_label;
      hi = open_label();
    end
    return (hi == OCT_TEN) ||
           (hi == OCT_172 && (lo & MASK_172_LO) == PREF_172_LO) ||
           (hi == OCT_192 && lo == OCT_168);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------

  function void push_req(byte_t b, bit present, logic [15:0] qtype, bit first, bit last);
    name_req_t r;
    r.name_byte = b;
    r.present   = present;
    r.qtype     = qtype;
    r.first     = first;
    r.last      = last;
    req_q.push_back(r);
    pushed_cnt++;
  endfunction

  function void add_byte(byte_t b);
    name_buf.push_back(b);
  endfunction

  function void add_text(string t);
    for (int i = 0; i < t.len(); i++) name_buf.push_back(byte_t'(t[i]));
  endfunction

  // Write one label that reads as v in one of several spellings, or a broken label
  function void add_label(byte_t v);
    int val;
    int unsigned pick;
    val  = int'(v);
    pick = $urandom_range(8, 13);
    case ($urandom_range(0, 11))
      0: add_text($sformatf("%0d", val + 256 * $urandom_range(1, 4)));
      1: add_text($sformatf("-%0d", (256 - val) % 256 + 256 * $urandom_range(0, 1)));
      2: add_text($sformatf("+%0d", val));
      3: begin
        add_byte(pick == 8 ? CH_SPACE : byte_t'(pick));
        add_text($sformatf("%0d", val));
      end
      4: add_text($sformatf("0%0d", val));
      5: add_text($sformatf("%0dz", val));
      // broken labels: lone sign, blanks only, letters
      6: add_byte($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
      7: add_text("  ");
      8: add_text("x7");
      default: add_text($sformatf("%0d", val));
    endcase
  endfunction

  // Turn name_buf into requests, with loose framing now and then
  function void emit_name(logic [15:0] qtype);
    int  n;
    bit  lead_empty;
    bit  tail_empty;
    bit  no_first;
    n          = name_buf.size();
    lead_empty = (n == 0) || ($urandom_range(0, 7) == 0);
    tail_empty = (n == 0) || ($urandom_range(0, 7) == 0);
    no_first   = ($urandom_range(0, 24) == 0);
    if (lead_empty) push_req(8'($urandom), 1'b0, qtype, !no_first, 1'b0);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 11) == 0) push_req(8'($urandom), 1'b0, 16'($urandom), 1'b0, 1'b0);
      push_req(name_buf[i], 1'b1, (i == 0 && !lead_empty) ? qtype : 16'($urandom),
               i == 0 && !lead_empty && !no_first, i == n - 1 && !tail_empty);
    end
    if (tail_empty) push_req(8'($urandom), 1'b0, 16'($urandom), 1'b0, 1'b1);
    name_buf.delete();
  endfunction

  function void gen_reverse_name();
    byte_t       hi;
    byte_t       lo;
    int unsigned n_lab;
    int unsigned target;
    int unsigned spot;
    logic [15:0] qt;
    hi = 8'($urandom);
    lo = 8'($urandom);
    // aim the two top labels at private ranges and their near misses
    case ($urandom_range(0, 7))
      0, 1: hi = OCT_TEN;
      2, 3: begin
        hi = OCT_172;
        lo = 8'($urandom_range(16, 31));
      end
      4: begin
        hi = OCT_192;
        lo = OCT_168;
      end
      5: begin
        hi = OCT_172;
        lo = $urandom_range(0, 1) ? 8'd15 : 8'd32;
      end
      6: begin
        hi = $urandom_range(0, 1) ? OCT_192 : 8'd11;
        lo = 8'd169;
      end
      default: ;
    endcase
    // a rare long prefix pushes the suffix toward or past the byte limit
    if ($urandom_range(0, 14) == 0) begin
      target = $urandom_range(96, 136);
      while (name_buf.size() < target) add_text($sformatf("%0d.", $urandom_range(0, 255)));
    end
    if ($urandom_range(0, 5) == 0) add_byte(CH_DOT);
    n_lab = $urandom_range(0, 4);
    for (int i = n_lab; i > 0; i--) begin
      add_label(i == 1 ? hi : (i == 2 ? lo : 8'($urandom)));
      if (i > 1) begin
        add_byte(CH_DOT);
        if ($urandom_range(0, 9) == 0) add_byte(CH_DOT);
      end
    end
    // an extra dot closes the top label before the suffix
    if ($urandom_range(0, 7) == 0) add_byte(CH_DOT);
    case ($urandom_range(0, 9))
      7: begin
        add_text(".in-addr.arpa");
        spot = name_buf.size() - 1 - $urandom_range(0, WIN_LEN - 1);
        name_buf[spot] = name_buf[spot] ^ 8'h20;
      end
      8: add_text(".in-addr.arp");
      9: ;
      default: begin
        add_text(".in-addr.arpa");
        if ($urandom_range(0, 4) == 0) add_text($sformatf(".%0d", $urandom_range(0, 255)));
      end
    endcase
    if ($urandom_range(0, 11) == 0) name_buf.insert($urandom_range(0, name_buf.size()), CH_NUL);
    qt = ($urandom_range(0, 7) == 0) ? 16'($urandom) : ptr_type_now;
    emit_name(qt);
  endfunction

  function void gen_noise();
    repeat ($urandom_range(1, 6))
      push_req(8'($urandom), 1'($urandom), 16'($urandom),
               $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
  endfunction

  function void fill_random(int unsigned n);
    int unsigned stop;
    stop = pushed_cnt + n;
    while (pushed_cnt < stop) begin
      if ($urandom_range(0, 9) == 0) gen_noise();
      else gen_reverse_name();
    end
  endfunction

  function int unsigned pick_gap();
    return ($urandom_range(0, 9) < 7) ? $urandom_range(1, 3) : $urandom_range(5, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, drivers and monitor
  // ---------------------------------------------------------------------------

  initial begin
    forever #1 clk = ~clk;
  end

  // Feed requests from req_q, holding each until it is taken
  always @(negedge clk) begin : feed_requests
    name_req_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!req_on_bus) begin
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (req_q.size() > 0) begin
        nxt = req_q.pop_front();
        s_tdata    <= {nxt.qtype, nxt.name_byte};
        s_tuser    <= {nxt.first, nxt.present};
        s_tlast    <= nxt.last;
        s_tvalid   <= 1'b1;
        req_on_bus = 1'b1;
        if (!steady && $urandom_range(0, 2) == 0) send_gap = pick_gap();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Stall the result side at random
  always @(negedge clk) begin
    if (take_stall > 0) begin
      take_stall--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (!steady && $urandom_range(0, 3) == 0) take_stall = pick_gap();
    end
  end

  // Predict on each accepted request, check each accepted result
  always @(posedge clk) begin : watch_streams
    bit want;
    if (!rst) begin
      if ($urandom_range(0, 99) == 0) steady = !steady;
      if (s_tvalid && s_tready) begin
        req_on_bus = 1'b0;
        if (s_tuser[1]) begin
          restart_name();
          held_type = s_tdata[23:8];
        end
        if (s_tuser[0]) shift_in_byte(s_tdata[7:0]);
        if (s_tlast) verdict_q.push_back(private_verdict());
      end
      if (m_tvalid && m_tready) begin
        if (verdict_q.size() == 0) begin
          $error("is_private: result %0d arrived with no name pending", m_tdata[0]);
          fail_cnt++;
        end else begin
          want = verdict_q.pop_front();
          if (m_tdata[0] !== want) begin
            $error("is_private: expected %0d, got %0d", want, m_tdata[0]);
            fail_cnt++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------

  // Write ptr_type_code and read it back
  task automatic program_ptr_type(input logic [15:0] code);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= PTR_TYPE_ADDR;
    pwdata  <= {16'($urandom), code};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    ptr_type_now = code;
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== PDATA_W'(code)) begin
      $error("ptr_type_code: expected 0x%0h, got 0x%0h", code, prdata);
      fail_cnt++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Wait until every request is taken and every result checked
  task automatic drain();
    while (req_q.size() > 0 || req_on_bus || verdict_q.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    s_tlast  = 1'b0;
    m_tready = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    restart_name();
    held_type    = 16'h0000;
    ptr_type_now = PTR_TYPE_RESET;

    // directed: a private name, a repeated last, extremes and empty requests
    add_text("10.in-addr.arpa");
    foreach (name_buf[i])
      push_req(name_buf[i], 1'b1, PTR_TYPE_RESET, i == 0, i == name_buf.size() - 1);
    name_buf.delete();
    push_req(8'hff, 1'b0, 16'hffff, 1'b0, 1'b1);
    push_req(CH_NUL, 1'b1, 16'h0000, 1'b1, 1'b1);
    push_req(8'hff, 1'b0, PTR_TYPE_RESET, 1'b1, 1'b0);
    push_req(8'hff, 1'b1, 16'hffff, 1'b0, 1'b0);
    push_req(CH_DOT, 1'b0, 16'h0000, 1'b0, 1'b1);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    fill_random(170);
    drain();
    program_ptr_type(16'hffff);
    fill_random(180);
    drain();
    program_ptr_type(16'h0000);
    fill_random(180);
    drain();
    program_ptr_type(16'($urandom));
    fill_random(180);
    drain();
    program_ptr_type(PTR_TYPE_RESET);
    fill_random(180);
    drain();

    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
